// File: hdl/twao_pkg.sv
package twao_pkg;

	localparam int DIV_NW = 57;

	localparam logic [1:0] REG_IPC  = 2'd0;
	localparam logic [1:0] REG_LOFF = 2'd1;
	localparam logic [1:0] REG_ROFF = 2'd2;
	localparam logic [1:0] REG_BOFF = 2'd3;

	localparam logic [23:0] IPC_RESET  = 24'd366027;
	localparam logic [15:0] LOFF_RESET = 16'd1280;
	localparam logic [15:0] ROFF_RESET = 16'd1280;
	localparam logic [15:0] BOFF_RESET = 16'd1280;

	localparam logic signed [36:0] PI_Q32      = 37'sd13493037705;
	localparam logic signed [36:0] TWO_PI_Q32  = 37'sd26986075409;
	localparam logic signed [36:0] HALF_PI_Q32 = 37'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

	// Full turn scaled by 128; the largest step of the angle reduction.
	localparam logic signed [43:0] TWO_PI_Q32_X128 = 44'sd3454217652352;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [57:0] quot;
		logic signed [36:0] rem;
	} div_res_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [31:0] sin;
		logic signed [31:0] cos;
	} cordic_res_t;

	function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
		logic signed [34:0] v;
		case (i)
			5'd0:  v = 35'sd843314856;
			5'd1:  v = 35'sd497837829;
			5'd2:  v = 35'sd263043836;
			5'd3:  v = 35'sd133525158;
			5'd4:  v = 35'sd67021686;
			5'd5:  v = 35'sd33543515;
			5'd6:  v = 35'sd16775850;
			5'd7:  v = 35'sd8388437;
			5'd8:  v = 35'sd4194282;
			5'd9:  v = 35'sd2097149;
			5'd10: v = 35'sd1048575;
			5'd11: v = 35'sd524287;
			5'd12: v = 35'sd262143;
			5'd13: v = 35'sd131071;
			5'd14: v = 35'sd65535;
			5'd15: v = 35'sd32767;
			5'd16: v = 35'sd16383;
			5'd17: v = 35'sd8191;
			5'd18: v = 35'sd4095;
			5'd19: v = 35'sd2047;
			5'd20: v = 35'sd1023;
			5'd21: v = 35'sd511;
			5'd22: v = 35'sd255;
			5'd23: v = 35'sd127;
			5'd24: v = 35'sd63;
			5'd25: v = 35'sd31;
			5'd26: v = 35'sd15;
			5'd27: v = 35'sd7;
			5'd28: v = 35'sd3;
			5'd29: v = 35'sd1;
			default: v = 35'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/twao_div.sv
module twao_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [56:0]    dividend,
	input  logic signed [35:0]    divisor,
	output twao_pkg::div_res_t    res
);

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t     state_q;
	logic [56:0] n_q;
	logic [35:0] rem_q;
	logic [35:0] d_q;
	logic [5:0]  cnt_q;
	logic        qneg_q;
	logic        rneg_q;
	logic        done_q;

	logic [36:0] shifted;
	logic [37:0] trial;
	logic signed [57:0] qmag;
	logic signed [36:0] rmag;

	assign shifted = {rem_q, n_q[56]};
	assign trial   = {1'b0, shifted} - {2'b0, d_q};
	assign qmag    = $signed({1'b0, n_q});
	assign rmag    = $signed({1'b0, rem_q});

	assign res.busy = (state_q == D_RUN);
	assign res.done = done_q;
	assign res.quot = qneg_q ? -qmag : qmag;
	assign res.rem  = rneg_q ? -rmag : rmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						n_q     <= dividend[56] ? 57'(-dividend) : 57'(dividend);
						d_q     <= divisor[35] ? 36'(-divisor) : 36'(divisor);
						rem_q   <= '0;
						qneg_q  <= dividend[56] ^ divisor[35];
						rneg_q  <= dividend[56];
						cnt_q   <= '0;
						done_q  <= 1'b0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					// One restoring step per cycle; quotient bits enter at the bottom.
					if (!trial[37]) begin
						rem_q <= trial[35:0];
					end else begin
						rem_q <= shifted[35:0];
					end
					n_q <= {n_q[55:0], !trial[37]};
					if (cnt_q == 6'(twao_pkg::DIV_NW - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/twao_cordic.sv
module twao_cordic #(
	parameter int STEPS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [40:0]     angle,
	output twao_pkg::cordic_res_t  res
);

	typedef enum logic [2:0] {
		C_IDLE, C_WRAP, C_MOD, C_HALF, C_FOLD, C_PREP, C_ITER
	} cstate_t;

	cstate_t            state_q;
	logic signed [43:0] r_q;
	logic signed [43:0] m_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [34:0] z_q;
	logic [4:0]         i_q;
	logic               neg_q;
	logic               done_q;

	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [34:0] at;
	logic signed [33:0] sn_full;
	logic signed [33:0] cs_full;

	assign dx      = y_q >>> i_q;
	assign dy      = x_q >>> i_q;
	assign at      = twao_pkg::atan_q30(i_q);
	assign sn_full = neg_q ? -y_q : y_q;
	assign cs_full = neg_q ? -x_q : x_q;

	assign res.busy = (state_q != C_IDLE);
	assign res.done = done_q;
	assign res.sin  = sn_full[31:0];
	assign res.cos  = cs_full[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						r_q     <= 44'(angle);
						neg_q   <= 1'b0;
						done_q  <= 1'b0;
						state_q <= C_WRAP;
					end
				end
				C_WRAP: begin
					// Lift negative angles by a multiple of a full turn so the
					// reduction below only has to subtract.
					if (r_q < 0) begin
						r_q <= r_q + twao_pkg::TWO_PI_Q32_X128;
					end
					m_q     <= twao_pkg::TWO_PI_Q32_X128;
					i_q     <= '0;
					state_q <= C_MOD;
				end
				C_MOD: begin
					// Compare and subtract 2*pi*2^k for k from 7 down to 0.
					if (r_q >= m_q) begin
						r_q <= r_q - m_q;
					end
					m_q <= m_q >>> 1;
					if (i_q == 5'd7) begin
						state_q <= C_HALF;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end
				C_HALF: begin
					if (r_q > twao_pkg::PI_Q32) begin
						r_q <= r_q - twao_pkg::TWO_PI_Q32;
					end
					state_q <= C_FOLD;
				end
				C_FOLD: begin
					// Angles beyond a quarter turn are moved by a half turn and the result negated.
					if (r_q > twao_pkg::HALF_PI_Q32) begin
						r_q   <= r_q - twao_pkg::PI_Q32;
						neg_q <= 1'b1;
					end else if (r_q < -twao_pkg::HALF_PI_Q32) begin
						r_q   <= r_q + twao_pkg::PI_Q32;
						neg_q <= 1'b1;
					end
					state_q <= C_PREP;
				end
				C_PREP: begin
					z_q     <= 35'(r_q >>> 2);
					x_q     <= twao_pkg::GAIN_Q30;
					y_q     <= '0;
					i_q     <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					if (!z_q[34]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					if (i_q == 5'(STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/three_wheel_arc_odometry.sv
// Three-wheel arc odometry. Each input transaction carries one sample of the absolute left,
// right and back encoder counts; the block answers each with one pose transaction (x, y in
// Q16.16 inches, heading in Q8.24 radians, all saturating). Items are handled one at a time.
// Each sample runs the bit-serial divider once on a straight step, twice on an arc and
// never with zero wheel spacing, and the iterative CORDIC, which reduces its angle by
// compare and subtract, once on a straight step and twice on an arc. All products go
// through one shared 33x33 multiplier. A finished pose waits in the output register, so
// the next sample can be taken while the previous result is still pending; a step stalls
// only if that pose has not been taken.
module three_wheel_arc_odometry #(
	parameter int CORDIC_STEPS = 24,
	parameter int COUNT_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // left_count, right_count, back_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // pose_x, pose_y, heading
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CB = COUNT_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_ML, S_MR, S_MS, S_DIVA, S_WDA, S_CHK, S_WC1, S_WK,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_HEAD, S_WC2,
		S_N1, S_N2, S_N3, S_N4, S_N5, S_N6, S_OUT
	} state_t;

	state_t state_q;

	logic [23:0]        ipc_q;
	logic [15:0]        loff_q;
	logic [15:0]        roff_q;
	logic [15:0]        boff_q;

	logic [CB-1:0]        prev_l_q, prev_r_q, prev_b_q;
	logic signed [CB-1:0] dl_q, dr_q, ds_q;
	logic signed [31:0]   l_q, r_q, s_q, a_q, sh_q, fwd_q, side_q, sn_q, cs_q;
	logic signed [32:0]   k_q;
	logic signed [38:0]   half_q;
	logic signed [65:0]   p_q, t_q;
	logic signed [66:0]   u_q;
	logic signed [31:0]   acc_x_q, acc_y_q, acc_h_q;
	logic                 out_valid_q;
	logic [95:0]          out_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	logic [16:0]        spacing;
	logic signed [32:0] lmr;
	logic signed [38:0] half_c;
	logic signed [40:0] head_ang;
	logic signed [40:0] cor_ang;
	logic signed [31:0] sat_dist;

	logic               div_start;
	logic signed [56:0] div_n;
	logic signed [35:0] div_d;
	twao_pkg::div_res_t div_res;

	logic               cor_start;
	twao_pkg::cordic_res_t cor_res;

	logic wr;

	assign pready   = 1'b1;
	assign wr       = psel & penable & pwrite & pready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		case (paddr[3:2])
			twao_pkg::REG_IPC:  prdata = {8'b0, ipc_q};
			twao_pkg::REG_LOFF: prdata = {16'b0, loff_q};
			twao_pkg::REG_ROFF: prdata = {16'b0, roff_q};
			twao_pkg::REG_BOFF: prdata = {16'b0, boff_q};
			default:            prdata = '0;
		endcase
	end

	assign spacing  = {1'b0, loff_q} + {1'b0, roff_q};
	assign lmr      = 33'(l_q) - 33'(r_q);
	assign half_c   = $signed({a_q, 7'b0});
	assign head_ang = 41'($signed({acc_h_q, 8'b0})) + 41'(half_q);
	assign cor_ang  = (state_q == S_CHK) ? 41'(half_c) : head_ang;
	assign sat_dist = twao_pkg::sat32(68'(p_q >>> 8));

	always_comb begin
		case (state_q)
			S_ML:    begin ma = 33'(dl_q);   mb = $signed({9'b0, ipc_q}); end
			S_MR:    begin ma = 33'(dr_q);   mb = $signed({9'b0, ipc_q}); end
			S_MS:    begin ma = 33'(ds_q);   mb = $signed({9'b0, ipc_q}); end
			S_M1:    begin ma = 33'(r_q);    mb = k_q; end
			S_M2:    begin ma = $signed({17'b0, roff_q}); mb = 33'(sh_q); end
			S_M3:    begin ma = 33'(s_q);    mb = k_q; end
			S_M4:    begin ma = 33'($signed(boff_q)); mb = 33'(sh_q); end
			S_N1:    begin ma = 33'(fwd_q);  mb = 33'(sn_q); end
			S_N2:    begin ma = 33'(side_q); mb = 33'(cs_q); end
			S_N3:    begin ma = 33'(fwd_q);  mb = 33'(cs_q); end
			S_N4:    begin ma = 33'(side_q); mb = 33'(sn_q); end
			default: begin ma = '0;          mb = '0; end
		endcase
	end

	assign prod = ma * mb;

	always_comb begin
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		cor_start = 1'b0;
		case (state_q)
			S_DIVA: begin
				div_start = (spacing != 17'd0);
				div_n     = 57'($signed({lmr, 16'b0}));
				div_d     = $signed({19'b0, spacing});
			end
			S_CHK: cor_start = (a_q != 32'sd0);
			S_WC1: begin
				div_start = cor_res.done;
				div_n     = $signed({cor_res.sin, 25'b0});
				div_d     = 36'(a_q);
			end
			S_HEAD:  cor_start = 1'b1;
			default: ;
		endcase
	end

	twao_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.res      (div_res)
	);

	twao_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_ang),
		.res    (cor_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ipc_q       <= twao_pkg::IPC_RESET;
			loff_q      <= twao_pkg::LOFF_RESET;
			roff_q      <= twao_pkg::ROFF_RESET;
			boff_q      <= twao_pkg::BOFF_RESET;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			prev_b_q    <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_h_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			p_q <= prod;
			if (wr) begin
				case (paddr[3:2])
					twao_pkg::REG_IPC:  ipc_q  <= pwdata[23:0];
					twao_pkg::REG_LOFF: loff_q <= pwdata[15:0];
					twao_pkg::REG_ROFF: roff_q <= pwdata[15:0];
					twao_pkg::REG_BOFF: boff_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && m_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						dl_q     <= $signed(s_tdata[CB-1:0] - prev_l_q);
						dr_q     <= $signed(s_tdata[32+CB-1:32] - prev_r_q);
						ds_q     <= $signed(s_tdata[64+CB-1:64] - prev_b_q);
						prev_l_q <= s_tdata[CB-1:0];
						prev_r_q <= s_tdata[32+CB-1:32];
						prev_b_q <= s_tdata[64+CB-1:64];
						state_q  <= S_ML;
					end
				end
				S_ML: state_q <= S_MR;
				S_MR: begin
					l_q     <= sat_dist;
					state_q <= S_MS;
				end
				S_MS: begin
					r_q     <= sat_dist;
					state_q <= S_DIVA;
				end
				S_DIVA: begin
					s_q <= sat_dist;
					if (spacing == 17'd0) begin
						a_q     <= '0;
						state_q <= S_CHK;
					end else begin
						state_q <= S_WDA;
					end
				end
				S_WDA: begin
					if (div_res.done) begin
						a_q     <= twao_pkg::sat32(68'(div_res.quot));
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (a_q == 32'sd0) begin
						fwd_q   <= r_q;
						side_q  <= s_q;
						half_q  <= '0;
						state_q <= S_HEAD;
					end else begin
						half_q  <= half_c;
						state_q <= S_WC1;
					end
				end
				S_WC1: begin
					if (cor_res.done) begin
						sh_q    <= cor_res.sin;
						state_q <= S_WK;
					end
				end
				S_WK: begin
					if (div_res.done) begin
						if (div_res.quot > 58'sd2147483648) begin
							k_q <= 33'sd2147483648;
						end else if (div_res.quot < -58'sd2147483648) begin
							k_q <= -33'sd2147483648;
						end else begin
							k_q <= div_res.quot[32:0];
						end
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					t_q     <= p_q >>> 30;
					state_q <= S_M3;
				end
				S_M3: begin
					fwd_q   <= twao_pkg::sat32(68'(t_q) + 68'(p_q >>> 21));
					state_q <= S_M4;
				end
				S_M4: begin
					t_q     <= p_q >>> 30;
					state_q <= S_M5;
				end
				S_M5: begin
					side_q  <= twao_pkg::sat32(68'(t_q) + 68'(p_q >>> 21));
					state_q <= S_HEAD;
				end
				S_HEAD: state_q <= S_WC2;
				S_WC2: begin
					if (cor_res.done) begin
						sn_q    <= cor_res.sin;
						cs_q    <= cor_res.cos;
						state_q <= S_N1;
					end
				end
				S_N1: state_q <= S_N2;
				S_N2: begin
					t_q     <= p_q;
					state_q <= S_N3;
				end
				S_N3: begin
					u_q     <= 67'(t_q) + 67'(p_q);
					state_q <= S_N4;
				end
				S_N4: begin
					acc_x_q <= twao_pkg::sat32(68'(acc_x_q) + 68'(u_q >>> 30));
					t_q     <= p_q;
					state_q <= S_N5;
				end
				S_N5: begin
					u_q     <= 67'(t_q) - 67'(p_q);
					state_q <= S_N6;
				end
				S_N6: begin
					acc_y_q <= twao_pkg::sat32(68'(acc_y_q) + 68'(u_q >>> 30));
					acc_h_q <= twao_pkg::sat32(68'(acc_h_q) + 68'(a_q));
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hold the new pose until the previous one has been taken.
					if (!out_valid_q || m_tready) begin
						out_q       <= {acc_h_q, acc_y_q, acc_x_q};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_res.busy)
		else $error("divider started while busy");

	a_cor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cor_start |-> !cor_res.busy)
		else $error("cordic started while busy");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second sample taken before the first was processed");

endmodule
